FILE: design/llss_pkg.sv
// Shared constants and helpers for the low-level smooth source block.
// No dependencies; every other file of the block but llss_div imports this package.
package llss_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int MAG_W      = DATA_W - 1;
	localparam int QUO_W      = DATA_W + FRAC_W;
	localparam int SQ_W       = 2 * MAG_W + 1;
	localparam int SQRT_STEPS = (SQ_W + 1) / 2;
	// divider, ramp, square, sum, root steps, halving, divider, clamp
	localparam int RAMP_LAT   = 2 * QUO_W + SQRT_STEPS + 5;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-1:0] REG_DENS_THR = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] REG_DENS_WID = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] REG_TEMP_THR = ADDR_W'(2);
	localparam logic [ADDR_W-1:0] REG_TEMP_WID = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] REG_TIME_SCL = ADDR_W'(4);

	localparam logic signed [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [MAG_W-1:0]         MAG_MAX = '1;
	localparam logic [DATA_W:0]          ONE_Q =
		{{(DATA_W-FRAC_W){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

	localparam logic signed [DATA_W-1:0] THR_RST = 32'hFFFF_0000;
	localparam logic [MAG_W-1:0]         WID_RST = 31'd66;
	localparam logic [MAG_W-1:0]         TSC_RST = 31'h0001_0000;

	// Magnitude of a signed value; the most negative value maps to 2^(DATA_W-1).
	function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
		logic [DATA_W-1:0] m;
		m = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
		return m;
	endfunction

endpackage

FILE: design/llss_if.sv
// Handshake channels of the low-level smooth source block: cell items in,
// source items out. Depends on llss_pkg for the field widths.
interface llss_feed_if;
	import llss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] density;
	logic signed [DATA_W-1:0] temperature;
	logic                     pressure_present;
	modport source (output valid, density, temperature, pressure_present, input ready);
	modport sink (input valid, density, temperature, pressure_present, output ready);
endinterface

interface llss_result_if;
	import llss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] density_term;
	logic signed [DATA_W-1:0] energy_term;
	logic                     density_valid;
	logic                     energy_valid;
	modport source (output valid, density_term, energy_term, density_valid,
		energy_valid, input ready);
	modport sink (input valid, density_term, energy_term, density_valid,
		energy_valid, output ready);
endinterface

FILE: design/llss_div.sv
// Pipelined restoring divider, one quotient bit per stage, NUM_W stages.
// No package dependency; advances only when en is high.
module llss_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 31
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s [NUM_W];
	logic [DEN_W-1:0] rem_in [NUM_W];
	logic [NUM_W-1:0] nq_in [NUM_W];
	logic [DEN_W-1:0] rem_nx [NUM_W];
	logic [NUM_W-1:0] nq_nx [NUM_W];
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	// nq holds the unused dividend bits on top and the quotient bits below
	always_comb begin
		rem_in[0] = '0;
		nq_in[0]  = num;
		for (int k = 1; k < NUM_W; k++) begin
			rem_in[k] = rem_s[k-1];
			nq_in[k]  = nq_s[k-1];
		end
		for (int k = 0; k < NUM_W; k++) begin
			trial = {rem_in[k], nq_in[k][NUM_W-1]};
			diff  = trial - {1'b0, den};
			if (trial >= {1'b0, den}) begin
				rem_nx[k] = diff[DEN_W-1:0];
				nq_nx[k]  = {nq_in[k][NUM_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = trial[DEN_W-1:0];
				nq_nx[k]  = {nq_in[k][NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				rem_s[k] <= rem_nx[k];
				nq_s[k]  <= nq_nx[k];
			end
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

FILE: design/llss_ramp.sv
// Smooth ramp s(x) = (r + sqrt(r*r + w*w)) / 2 / ts with r = 1 - x/thr,
// fully pipelined over RAMP_LAT stages. Uses llss_pkg and llss_div.
module llss_ramp (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [llss_pkg::DATA_W-1:0] x,
	input  logic signed [llss_pkg::DATA_W-1:0] thr,
	input  logic [llss_pkg::MAG_W-1:0]        w,
	input  logic [llss_pkg::MAG_W-1:0]        ts,
	output logic [llss_pkg::MAG_W-1:0]        y
);
	import llss_pkg::*;

	logic [QUO_W-1:0]    num1;
	logic [QUO_W-1:0]    q1;
	logic                neg_s [QUO_W];
	logic [MAG_W-1:0]    qs;
	logic signed [DATA_W:0] rr;
	logic [DATA_W:0]     rr_neg;
	logic [MAG_W-1:0]    ur_s1, ur_s2, ur_s3;
	logic                rneg_s1, rneg_s2, rneg_s3;
	logic [2*MAG_W-1:0]  r2_s2, w2_s2;
	logic [SQ_W-1:0]     sum_s3;
	logic [SQ_W-1:0]     sqn_s [SQRT_STEPS];
	logic [SQ_W-1:0]     sqr_s [SQRT_STEPS];
	logic [MAG_W-1:0]    urd_s [SQRT_STEPS];
	logic                rnd_s [SQRT_STEPS];
	logic [SQ_W-1:0]     sqn_in [SQRT_STEPS];
	logic [SQ_W-1:0]     sqr_in [SQRT_STEPS];
	logic [SQ_W-1:0]     sqn_nx [SQRT_STEPS];
	logic [SQ_W-1:0]     sqr_nx [SQRT_STEPS];
	logic [SQ_W:0]       bit_k;
	logic [SQ_W:0]       sq_trial;
	logic [DATA_W:0]     root;
	logic [DATA_W:0]     tsum;
	logic [DATA_W-1:0]   half_s4;
	logic                hz_s [QUO_W];
	logic [QUO_W-1:0]    q2;
	logic [MAG_W-1:0]    y_s5;

	// x/thr on magnitudes, with the fraction shifted in
	assign num1 = {mag_of(x), {FRAC_W{1'b0}}};

	llss_div #(.NUM_W(QUO_W), .DEN_W(MAG_W)) u_qdiv (
		.clk (clk),
		.en  (en),
		.num (num1),
		.den (thr[MAG_W-1:0]),
		.quo (q1)
	);

	// r = 1 - q (1 + q for negative x) with the quotient clamped and r saturated high
	always_comb begin
		qs     = (q1[QUO_W-1:MAG_W] != '0) ? MAG_MAX : q1[MAG_W-1:0];
		rr     = neg_s[QUO_W-1] ? $signed(ONE_Q + {2'b00, qs}) : $signed(ONE_Q - {2'b00, qs});
		rr_neg = (DATA_W+1)'(-rr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= x[DATA_W-1];
			for (int k = 1; k < QUO_W; k++) begin
				neg_s[k] <= neg_s[k-1];
			end
			if (!rr[DATA_W] && rr[DATA_W-1]) begin
				ur_s1   <= MAG_MAX;
				rneg_s1 <= 1'b0;
			end else if (rr[DATA_W]) begin
				ur_s1   <= rr_neg[MAG_W-1:0];
				rneg_s1 <= 1'b1;
			end else begin
				ur_s1   <= rr[MAG_W-1:0];
				rneg_s1 <= 1'b0;
			end
			r2_s2   <= ur_s1 * ur_s1;
			w2_s2   <= w * w;
			ur_s2   <= ur_s1;
			rneg_s2 <= rneg_s1;
			sum_s3  <= {1'b0, r2_s2} + {1'b0, w2_s2};
			ur_s3   <= ur_s2;
			rneg_s3 <= rneg_s2;
		end
	end

	// floor square root, one result bit per stage
	always_comb begin
		sqn_in[0] = sum_s3;
		sqr_in[0] = '0;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			sqn_in[k] = sqn_s[k-1];
			sqr_in[k] = sqr_s[k-1];
		end
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bit_k    = (SQ_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
			sq_trial = {1'b0, sqr_in[k]} + bit_k;
			if ({1'b0, sqn_in[k]} >= sq_trial) begin
				sqn_nx[k] = SQ_W'({1'b0, sqn_in[k]} - sq_trial);
				sqr_nx[k] = SQ_W'({1'b0, sqr_in[k] >> 1} + bit_k);
			end else begin
				sqn_nx[k] = sqn_in[k];
				sqr_nx[k] = sqr_in[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			urd_s[0] <= ur_s3;
			rnd_s[0] <= rneg_s3;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				urd_s[k] <= urd_s[k-1];
				rnd_s[k] <= rnd_s[k-1];
			end
			for (int k = 0; k < SQRT_STEPS; k++) begin
				sqn_s[k] <= sqn_nx[k];
				sqr_s[k] <= sqr_nx[k];
			end
		end
	end

	// root never falls below |r|, so the difference stays nonnegative
	always_comb begin
		root = sqr_s[SQRT_STEPS-1][DATA_W:0];
		tsum = rnd_s[SQRT_STEPS-1] ? root - {2'b00, urd_s[SQRT_STEPS-1]}
			: root + {2'b00, urd_s[SQRT_STEPS-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_s4 <= tsum[DATA_W:1];
		end
	end

	llss_div #(.NUM_W(QUO_W), .DEN_W(MAG_W)) u_tdiv (
		.clk (clk),
		.en  (en),
		.num ({half_s4, {FRAC_W{1'b0}}}),
		.den (ts),
		.quo (q2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			hz_s[0] <= (half_s4 == '0);
			for (int k = 1; k < QUO_W; k++) begin
				hz_s[k] <= hz_s[k-1];
			end
			if (ts == '0) begin
				y_s5 <= hz_s[QUO_W-1] ? '0 : MAG_MAX;
			end else if (q2[QUO_W-1:MAG_W] != '0) begin
				y_s5 <= MAG_MAX;
			end else begin
				y_s5 <= q2[MAG_W-1:0];
			end
		end
	end

	assign y = y_s5;

endmodule

FILE: design/low_level_smooth_source.sv
// Top level of the low-level smooth source block: config registers, two ramp
// pipelines, the 1.5 product and sum stages, output register and skid stage.
// Depends on llss_pkg, llss_if (llss_feed_if, llss_result_if) and llss_ramp.

// Per grid cell this block turns density N and temperature T (signed Q16.16)
// into floor-keeping sources: the density term is s(N) when density_threshold
// is positive, the energy term is 1.5*T*s(N) (with pressure_present and a
// positive density_threshold) plus 1.5*N*s(T) (when temperature_threshold is
// positive), each saturated to 32 bits, with valid flags telling which terms
// were produced. It takes one cell every clock cycle while the pipeline is not
// held. Each ramp holds two bit-per-stage dividers (48 stages each) and a
// 32-stage square root. The whole pipeline advances together and holds while
// the output register and the skid stage are both full; ready comes straight
// from the skid register. Write configuration only while no item is
// in flight.
module low_level_smooth_source (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [llss_pkg::ADDR_W-1:0]  wr_index,
	input  logic [llss_pkg::DATA_W-1:0]  wr_data,
	llss_feed_if.sink                    feed,
	llss_result_if.source                result
);
	import llss_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] density;
		logic signed [DATA_W-1:0] temperature;
		logic                     pressure_present;
	} cell_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] density_term;
		logic signed [DATA_W-1:0] energy_term;
		logic                     density_valid;
		logic                     energy_valid;
	} res_t;

	// Saturate a magnitude and apply the sign.
	function automatic logic signed [DATA_W-1:0] to_signed(
		input logic [2*DATA_W-1:0] m, input logic neg);
		logic signed [DATA_W-1:0] v;
		if (m[2*DATA_W-1:DATA_W-1] != '0) begin
			v = neg ? MIN_V : MAX_V;
		end else begin
			v = neg ? -$signed(m[DATA_W-1:0]) : $signed(m[DATA_W-1:0]);
		end
		return v;
	endfunction

	// Configuration registers
	logic signed [DATA_W-1:0] dens_thr_q, temp_thr_q;
	logic [MAG_W-1:0]         dens_wid_q, temp_wid_q, time_scl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dens_thr_q <= THR_RST;
			dens_wid_q <= WID_RST;
			temp_thr_q <= THR_RST;
			temp_wid_q <= WID_RST;
			time_scl_q <= TSC_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DENS_THR: dens_thr_q <= wr_data;
				REG_DENS_WID: dens_wid_q <= wr_data[MAG_W-1:0];
				REG_TEMP_THR: temp_thr_q <= wr_data;
				REG_TEMP_WID: temp_wid_q <= wr_data[MAG_W-1:0];
				REG_TIME_SCL: time_scl_q <= wr_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: every stage moves unless the skid stage holds an item.
	logic adv;
	logic skid_v_q, out_v_q;
	res_t skid_d_q, out_d_q;

	assign adv        = !skid_v_q;
	assign feed.ready = adv;

	// Both ramps run in lockstep with the cell delay line.
	logic [MAG_W-1:0] dramp, tramp;

	llss_ramp u_dramp (
		.clk (clk),
		.en  (adv),
		.x   (feed.density),
		.thr (dens_thr_q),
		.w   (dens_wid_q),
		.ts  (time_scl_q),
		.y   (dramp)
	);

	llss_ramp u_tramp (
		.clk (clk),
		.en  (adv),
		.x   (feed.temperature),
		.thr (temp_thr_q),
		.w   (temp_wid_q),
		.ts  (time_scl_q),
		.y   (tramp)
	);

	// Cell fields and valid bits ride alongside the ramps.
	cell_t dl_s [RAMP_LAT];
	logic  vl_s [RAMP_LAT];
	cell_t cur;

	assign cur = dl_s[RAMP_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dl_s[0] <= '{density: feed.density, temperature: feed.temperature,
				pressure_present: feed.pressure_present};
			for (int k = 1; k < RAMP_LAT; k++) begin
				dl_s[k] <= dl_s[k-1];
			end
		end
	end

	// Stage 1: raw products |T|*s(N) and |N|*s(T)
	logic [DATA_W+MAG_W-1:0] pa_s1, pb_s1;
	logic                    nega_s1, negb_s1, pres_s1;
	logic [MAG_W-1:0]        dsrc_s1;
	// Stage 2: times 3, drop FRAC_W+1 bits, saturate
	logic [2*DATA_W-1:0]     pa3, pb3;
	logic signed [DATA_W-1:0] ta_s2, tb_s2;
	logic                    pres_s2;
	logic [MAG_W-1:0]        dsrc_s2;
	// Stage 3: pick and sum terms
	logic signed [DATA_W:0]  esum;
	logic signed [DATA_W-1:0] esat;
	logic                    dens_on, temp_on, pres_on;
	res_t                    res_s3;
	logic                    v_s1, v_s2, v_s3;

	always_comb begin
		pa3     = ({1'b0, pa_s1} + {pa_s1, 1'b0}) >> (FRAC_W + 1);
		pb3     = ({1'b0, pb_s1} + {pb_s1, 1'b0}) >> (FRAC_W + 1);
		esum    = {ta_s2[DATA_W-1], ta_s2} + {tb_s2[DATA_W-1], tb_s2};
		if (esum[DATA_W] != esum[DATA_W-1]) begin
			esat = esum[DATA_W] ? MIN_V : MAX_V;
		end else begin
			esat = esum[DATA_W-1:0];
		end
		dens_on = !dens_thr_q[DATA_W-1] && (dens_thr_q != '0);
		temp_on = !temp_thr_q[DATA_W-1] && (temp_thr_q != '0);
		pres_on = dens_on && pres_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1   <= mag_of(cur.temperature) * dramp;
			pb_s1   <= mag_of(cur.density) * tramp;
			nega_s1 <= cur.temperature[DATA_W-1];
			negb_s1 <= cur.density[DATA_W-1];
			pres_s1 <= cur.pressure_present;
			dsrc_s1 <= dramp;

			ta_s2   <= to_signed(pa3, nega_s1);
			tb_s2   <= to_signed(pb3, negb_s1);
			pres_s2 <= pres_s1;
			dsrc_s2 <= dsrc_s1;

			res_s3.density_term  <= dens_on ? $signed({1'b0, dsrc_s2}) : '0;
			res_s3.density_valid <= dens_on;
			res_s3.energy_valid  <= pres_on || temp_on;
			if (pres_on && temp_on) begin
				res_s3.energy_term <= esat;
			end else if (pres_on) begin
				res_s3.energy_term <= ta_s2;
			end else if (temp_on) begin
				res_s3.energy_term <= tb_s2;
			end else begin
				res_s3.energy_term <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RAMP_LAT; k++) begin
				vl_s[k] <= 1'b0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			vl_s[0] <= feed.valid;
			for (int k = 1; k < RAMP_LAT; k++) begin
				vl_s[k] <= vl_s[k-1];
			end
			v_s1 <= vl_s[RAMP_LAT-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Output register plus skid: while advancing, an item that cannot enter
	// the stalled output register parks in the skid stage; drain it first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!out_v_q || result.ready) begin
				out_v_q <= v_s3;
			end else if (v_s3) begin
				skid_v_q <= 1'b1;
			end
		end else if (result.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!out_v_q || result.ready) begin
				out_d_q <= res_s3;
			end else begin
				skid_d_q <= res_s3;
			end
		end else if (result.ready) begin
			out_d_q <= skid_d_q;
		end
	end

	assign result.valid         = out_v_q;
	assign result.density_term  = out_d_q.density_term;
	assign result.energy_term   = out_d_q.energy_term;
	assign result.density_valid = out_d_q.density_valid;
	assign result.energy_valid  = out_d_q.energy_valid;

	// A parked item always sits behind a held output item.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds an item while the output register is empty");

	a_dens_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.density_valid) |-> (result.density_term == '0))
		else $error("density term nonzero without its valid flag");

	a_energy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.energy_valid) |-> (result.energy_term == '0))
		else $error("energy term nonzero without its valid flag");

endmodule
